>>> hw/rtl/config_text_tokenizer_macros.svh
// Assertion helpers; the using module must provide clk and rst_n.
`ifndef CONFIG_TEXT_TOKENIZER_MACROS_SVH
`define CONFIG_TEXT_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");

// Next-cycle implication, disabled during reset.
`define CT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");

`endif

>>> hw/rtl/cfg_tok_pkg.sv
package cfg_tok_pkg;

  localparam int TOKEN_DEPTH_DEF = 64;
  localparam int BYTE_W          = 8;
  localparam int LIMIT_W         = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
  localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;

  // Strobes from the sequencer to the token store.
  typedef struct packed {
    logic we;
    logic re;
  } store_ctl_t;

  function automatic logic is_white(input logic [BYTE_W-1:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_VT) ||
           (b == CH_FF) || (b == CH_CR);
  endfunction

  function automatic logic is_punct(input logic [BYTE_W-1:0] b);
    return (b == CH_LPAREN) || (b == CH_RPAREN) || (b == CH_LBRACE) ||
           (b == CH_RBRACE) || (b == CH_LBRACK) || (b == CH_RBRACK) ||
           (b == CH_COMMA) || (b == CH_SEMI) || (b == CH_COLON);
  endfunction

endpackage

>>> hw/rtl/cfg_tok_if.sv
interface cfg_tok_in_if import cfg_tok_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface cfg_tok_out_if import cfg_tok_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] tok_byte;
  logic              tok_last;

  modport source (output valid, output tok_byte, output tok_last, input ready);
  modport sink   (input valid, input tok_byte, input tok_last, output ready);
endinterface

>>> hw/rtl/cfg_tok_store.sv
module cfg_tok_store import cfg_tok_pkg::*; #(
  parameter int TOKEN_DEPTH = TOKEN_DEPTH_DEF,
  localparam int ADDR_W = $clog2(TOKEN_DEPTH)
) (
  input  logic              clk,
  input  store_ctl_t        ctl,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [BYTE_W-1:0] rdata_r
);

  logic [BYTE_W-1:0] mem [TOKEN_DEPTH];

  // Read data holds until the next read strobe.
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/cfg_tok_ctrl.sv
`include "config_text_tokenizer_macros.svh"

module cfg_tok_ctrl import cfg_tok_pkg::*; #(
  parameter int TOKEN_DEPTH = TOKEN_DEPTH_DEF,
  localparam int ADDR_W = $clog2(TOKEN_DEPTH),
  localparam int LEN_W  = $clog2(TOKEN_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  cfg_tok_in_if.sink         in_ch,
  cfg_tok_out_if.source      out_ch,
  output store_ctl_t         st_ctl,
  output logic [ADDR_W-1:0]  st_waddr,
  output logic [BYTE_W-1:0]  st_wdata,
  output logic [ADDR_W-1:0]  st_raddr,
  input  logic [BYTE_W-1:0]  st_rdata
);

  localparam logic [1:0] MODE_NORMAL  = 2'd0;
  localparam logic [1:0] MODE_QUOTE   = 2'd1;
  localparam logic [1:0] MODE_DISCARD = 2'd2;

  localparam logic [LIMIT_W-1:0] DEPTH_L = LIMIT_W'(TOKEN_DEPTH);

  logic [LIMIT_W-1:0] limit_r;
  logic [1:0]         mode_r, mode_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               allsp_r, allsp_nxt;
  logic [LEN_W-1:0]   rem_r, rem_nxt;
  logic [ADDR_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic               rd_last_r;
  logic               punct_pend_r, punct_pend_nxt;
  logic [BYTE_W-1:0]  punct_byte_r;
  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_byte_r;
  logic               out_last_r;

  logic [BYTE_W-1:0]  b;
  logic [LIMIT_W-1:0] lim, len_ext;
  logic               in_fire, flush_req, flush_go, punct_req, append_ok;
  logic               out_free, out_load, punct_load, rd_issue;
  logic               st_we;

  assign b       = in_ch.in_byte;
  assign lim     = (limit_r < DEPTH_L) ? limit_r : DEPTH_L;
  assign len_ext = LIMIT_W'(len_r);

  assign in_ch.ready = (rem_r == '0) && !rd_pend_r && !punct_pend_r;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign append_ok = (({1'b0, len_ext} + 8'd1) < {1'b0, lim}) && (len_ext < DEPTH_L);

  // Scanner: one byte decides mode, token length and store write.
  always_comb begin
    mode_nxt   = mode_r;
    len_nxt    = len_r;
    allsp_nxt  = allsp_r;
    flush_req  = 1'b0;
    punct_req  = 1'b0;
    st_we      = 1'b0;
    if (in_fire) begin
      case (mode_r)
        MODE_NORMAL: begin
          if (b == CH_LF) begin
            flush_req = 1'b1;
          end else if (b == CH_NUL || b == CH_HASH) begin
            flush_req = 1'b1;
            mode_nxt  = MODE_DISCARD;
          end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
            flush_req = 1'b1;
            mode_nxt  = MODE_QUOTE;
          end else if (is_punct(b) || b == CH_SPACE || b == CH_TAB || b == CH_CR) begin
            flush_req = 1'b1;
            if (lim <= LIMIT_W'(1)) begin
              mode_nxt = MODE_DISCARD;
            end else begin
              punct_req = is_punct(b);
            end
          end else if (append_ok) begin
            st_we     = 1'b1;
            len_nxt   = len_r + LEN_W'(1);
            if (!is_white(b)) allsp_nxt = 1'b0;
          end else begin
            len_nxt   = '0;
            allsp_nxt = 1'b1;
            mode_nxt  = MODE_DISCARD;
          end
        end
        MODE_QUOTE: begin
          if (b == CH_LF) begin
            len_nxt   = '0;
            allsp_nxt = 1'b1;
            mode_nxt  = MODE_NORMAL;
          end else if (b == CH_NUL || b == CH_HASH) begin
            len_nxt   = '0;
            allsp_nxt = 1'b1;
            mode_nxt  = MODE_DISCARD;
          end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
            if (len_ext >= lim) begin
              len_nxt   = '0;
              allsp_nxt = 1'b1;
              mode_nxt  = MODE_DISCARD;
            end else begin
              flush_req = 1'b1;
              mode_nxt  = MODE_NORMAL;
            end
          end else if (append_ok) begin
            st_we     = 1'b1;
            len_nxt   = len_r + LEN_W'(1);
            if (!is_white(b)) allsp_nxt = 1'b0;
          end else begin
            len_nxt   = '0;
            allsp_nxt = 1'b1;
            mode_nxt  = MODE_DISCARD;
          end
        end
        default: begin
          if (b == CH_LF) begin
            len_nxt   = '0;
            allsp_nxt = 1'b1;
            mode_nxt  = MODE_NORMAL;
          end
        end
      endcase
      if (flush_req) begin
        len_nxt   = '0;
        allsp_nxt = 1'b1;
      end
    end
  end

  assign flush_go = flush_req && (len_r != '0) && !allsp_r;
  assign st_waddr = len_r[ADDR_W-1:0];
  assign st_wdata = b;

  // Replay: read data waits in the store output until the output register frees.
  assign out_free   = !out_valid_r || out_ch.ready;
  assign out_load   = rd_pend_r && out_free;
  assign punct_load = !rd_pend_r && (rem_r == '0) && punct_pend_r && out_free;
  assign rd_issue   = (rem_r != '0) && (!rd_pend_r || out_load);
  assign st_ctl     = '{we: st_we, re: rd_issue};
  assign st_raddr   = rd_idx_r;

  always_comb begin
    rem_nxt        = rem_r;
    rd_idx_nxt     = rd_idx_r;
    rd_pend_nxt    = rd_pend_r;
    punct_pend_nxt = punct_pend_r;
    out_valid_nxt  = out_valid_r;
    if (flush_go) begin
      rem_nxt    = len_r;
      rd_idx_nxt = '0;
    end else if (rd_issue) begin
      rem_nxt    = rem_r - LEN_W'(1);
      rd_idx_nxt = rd_idx_r + ADDR_W'(1);
    end
    if (rd_issue) begin
      rd_pend_nxt = 1'b1;
    end else if (out_load) begin
      rd_pend_nxt = 1'b0;
    end
    if (punct_req) begin
      punct_pend_nxt = 1'b1;
    end else if (punct_load) begin
      punct_pend_nxt = 1'b0;
    end
    if (out_load || punct_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r      <= LIMIT_RESET;
      mode_r       <= MODE_NORMAL;
      len_r        <= '0;
      allsp_r      <= 1'b1;
      rem_r        <= '0;
      rd_idx_r     <= '0;
      rd_pend_r    <= 1'b0;
      punct_pend_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) limit_r <= cfg_wdata;
      mode_r       <= mode_nxt;
      len_r        <= len_nxt;
      allsp_r      <= allsp_nxt;
      rem_r        <= rem_nxt;
      rd_idx_r     <= rd_idx_nxt;
      rd_pend_r    <= rd_pend_nxt;
      punct_pend_r <= punct_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) rd_last_r <= (rem_r == LEN_W'(1));
    if (punct_req) punct_byte_r <= b;
    if (out_load) begin
      out_byte_r <= st_rdata;
      out_last_r <= rd_last_r;
    end else if (punct_load) begin
      out_byte_r <= punct_byte_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.tok_byte = out_byte_r;
  assign out_ch.tok_last = out_last_r;

  `CT_ASSERT_NEXT(a_flush_clears_len, flush_go, (len_r == '0) && (rem_r != '0))
  `CT_ASSERT_IMPL(a_last_ends_replay, out_load && rd_last_r, rem_r == '0)
  `CT_ASSERT_IMPL(a_len_in_store, 1'b1, len_ext < DEPTH_L)
  `CT_ASSERT_IMPL(a_no_write_in_replay, st_ctl.we, !rd_issue && !rd_pend_r)

endmodule

>>> hw/rtl/config_text_tokenizer.sv
// Config text tokenizer. Raw text bytes come in on in_ch, one byte per transaction;
// tokens leave on out_ch one byte per transaction with tok_last set on the final byte
// of each token. Bytes of a plain or quoted token are written into a single-port-write,
// registered-read token store as they arrive; a byte that ends a token then blocks the
// input while the token is replayed from the store through its read port, one byte per
// cycle when out_ch is ready, so the input stays blocked until the token's last byte and
// any punctuation token that follows it are loaded into the output register (a lone
// punctuation byte blocks it too). Separators outside quotes, quote characters and
// comments never reach the output. The one configuration register, token_limit
// (cfg_wdata, 7 bits, reset 64), is to be written with cfg_we only while the block is
// idle; the block itself does not enforce this. Tokens of min(token_limit, TOKEN_DEPTH)
// bytes or more are dropped together with the rest of their line. The store needs no
// clearing after reset: only entries already written for the current token are read back.
module config_text_tokenizer import cfg_tok_pkg::*; #(
  parameter int TOKEN_DEPTH = TOKEN_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  cfg_tok_in_if.sink         in_ch,
  cfg_tok_out_if.source      out_ch
);

  localparam int ADDR_W = $clog2(TOKEN_DEPTH);

  // Store strobes and addresses between sequencer and token store.
  store_ctl_t        st_ctl;
  logic [ADDR_W-1:0] st_waddr;
  logic [ADDR_W-1:0] st_raddr;
  logic [BYTE_W-1:0] st_wdata;
  logic [BYTE_W-1:0] st_rdata;

  // Scanner and replay sequencer: mode, token length and the output register.
  cfg_tok_ctrl #(
    .TOKEN_DEPTH (TOKEN_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .st_ctl    (st_ctl),
    .st_waddr  (st_waddr),
    .st_wdata  (st_wdata),
    .st_raddr  (st_raddr),
    .st_rdata  (st_rdata)
  );

  // Token bytes; read data is valid in the cycle after the read strobe.
  cfg_tok_store #(
    .TOKEN_DEPTH (TOKEN_DEPTH)
  ) u_store (
    .clk     (clk),
    .ctl     (st_ctl),
    .waddr   (st_waddr),
    .wdata   (st_wdata),
    .raddr   (st_raddr),
    .rdata_r (st_rdata)
  );

endmodule

>>> dv/tokenizer_checker.sv
`timescale 1ns / 1ps

module tokenizer_checker import cfg_tok_pkg::*; #(
  parameter int TOKEN_DEPTH = TOKEN_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  cfg_tok_in_if              in_ch,
  cfg_tok_out_if             out_ch,
  output int                 fail_count,
  output int                 beats_due,
  output int                 beats_seen,
  output int                 tokens_seen
);

  typedef enum logic [1:0] {SCAN_NORMAL, SCAN_QUOTE, SCAN_DISCARD} scan_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } tok_beat_t;

  // Shadow of the tokenizer state
  logic [BYTE_W-1:0]  word_buf [TOKEN_DEPTH];
  int unsigned        word_len;
  logic               blank_word;
  scan_e              scan;
  logic [LIMIT_W-1:0] limit_reg;
  tok_beat_t          beat_q [$];

  function automatic logic single_char(input logic [BYTE_W-1:0] b);
    return b inside {CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_LBRACK,
                     CH_RBRACK, CH_COMMA, CH_SEMI, CH_COLON};
  endfunction

  function automatic logic quote_char(input logic [BYTE_W-1:0] b);
    return b == CH_SQUOTE || b == CH_DQUOTE;
  endfunction

  function automatic int unsigned cap();
    return (limit_reg < TOKEN_DEPTH) ? limit_reg : TOKEN_DEPTH;
  endfunction

  function automatic void drop_word();
    word_len   = 0;
    blank_word = 1'b1;
  endfunction

  // whitespace-only words vanish
  function automatic void emit_word();
    if (word_len > 0 && !blank_word) begin
      for (int i = 0; i < word_len; i++) begin
        beat_q.push_back(tok_beat_t'{word_buf[i], (i + 1 == word_len)});
      end
    end
    drop_word();
  endfunction

  // overflow kills the word and the rest of the line
  function automatic void take_byte(input logic [BYTE_W-1:0] b);
    if (word_len + 1 >= cap() || word_len >= TOKEN_DEPTH) begin
      drop_word();
      scan = SCAN_DISCARD;
    end else begin
      word_buf[word_len] = b;
      word_len++;
      if (!(b inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR})) blank_word = 1'b0;
    end
  endfunction

  function automatic void predict(input logic [BYTE_W-1:0] b);
    case (scan)
      SCAN_NORMAL: begin
        if (b == CH_LF) begin
          emit_word();
        end else if (b == CH_NUL || b == CH_HASH) begin
          emit_word();
          scan = SCAN_DISCARD;
        end else if (quote_char(b)) begin
          emit_word();
          scan = SCAN_QUOTE;
        end else if (single_char(b) || b inside {CH_SPACE, CH_TAB, CH_CR}) begin
          emit_word();
          if (cap() <= 1) begin
            scan = SCAN_DISCARD;
          end else if (single_char(b)) begin
            beat_q.push_back(tok_beat_t'{b, 1'b1});
          end
        end else begin
          take_byte(b);
        end
      end
      SCAN_QUOTE: begin
        if (b == CH_LF) begin
          drop_word();
          scan = SCAN_NORMAL;
        end else if (b == CH_NUL || b == CH_HASH) begin
          drop_word();
          scan = SCAN_DISCARD;
        end else if (quote_char(b)) begin
          if (word_len >= cap()) begin
            drop_word();
            scan = SCAN_DISCARD;
          end else begin
            emit_word();
            scan = SCAN_NORMAL;
          end
        end else begin
          take_byte(b);
        end
      end
      default: begin
        if (b == CH_LF) begin
          drop_word();
          scan = SCAN_NORMAL;
        end
      end
    endcase
  endfunction

  // Inputs predicted before outputs are checked in the same edge
  always @(posedge clk) begin
    tok_beat_t want;
    if (!rst_n) begin
      drop_word();
      scan        = SCAN_NORMAL;
      limit_reg   = LIMIT_RESET;
      beat_q.delete();
      fail_count  = 0;
      beats_seen  = 0;
      tokens_seen = 0;
    end else begin
      if (cfg_we) limit_reg = cfg_wdata;
      if (in_ch.valid && in_ch.ready) predict(in_ch.in_byte);
      if (out_ch.valid && out_ch.ready) begin
        beats_seen++;
        if (out_ch.tok_last) tokens_seen++;
        if (beat_q.size() == 0) begin
          $display("%0t: token byte %h last %b arrived, expected none",
                   $time, out_ch.tok_byte, out_ch.tok_last);
          fail_count++;
        end else begin
          want = beat_q.pop_front();
          if (out_ch.tok_byte !== want.data) begin
            $display("%0t: tok_byte expected %h, actual %h",
                     $time, want.data, out_ch.tok_byte);
            fail_count++;
          end
          if (out_ch.tok_last !== want.last) begin
            $display("%0t: tok_last expected %b, actual %b (byte %h)",
                     $time, want.last, out_ch.tok_last, want.data);
            fail_count++;
          end
        end
      end
    end
    beats_due = beat_q.size();
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the config text tokenizer. The checker instance
// shadows the block; this module only feeds bytes, drives out_ch.ready, moves token_limit
// between phases and decides pass/fail.
module testbench;
  import cfg_tok_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  // Longest token replay plus margin; used before each limit write and at the end
  localparam int SETTLE_CYCLES = 80;
  localparam int PHASE_BYTES   = 75;

  localparam logic [BYTE_W-1:0] PUNCT  [9] = '{CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE,
                                               CH_LBRACK, CH_RBRACK, CH_COMMA, CH_SEMI,
                                               CH_COLON};
  localparam logic [BYTE_W-1:0] SEPS   [3] = '{CH_SPACE, CH_TAB, CH_CR};
  localparam logic [BYTE_W-1:0] QUOTES [2] = '{CH_SQUOTE, CH_DQUOTE};
  // Both extremes, a few in between; the second 64 phase runs with no idling
  localparam int PHASE_LIMIT [6] = '{64, 2, 9, 64, 3, 40};

  typedef logic [BYTE_W-1:0] byte_seq_t [$];

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = LIMIT_RESET;

  bit throttle = 1'b1;   // random idling on both channels when set
  int cycles = 0;
  int lim_now = LIMIT_RESET;
  int bytes_sent = 0;
  int limit_writes = 0;

  int fail_count;
  int beats_due;
  int beats_seen;
  int tokens_seen;

  cfg_tok_in_if  in_ch ();
  cfg_tok_out_if out_ch ();

  config_text_tokenizer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  tokenizer_checker tok_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .beats_due   (beats_due),
    .beats_seen  (beats_seen),
    .tokens_seen (tokens_seen)
  );

  always #1 clk = ~clk;

  // Hard stop in case the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sink side backpressure, changed on the falling edge like every other input
  always @(negedge clk) begin
    out_ch.ready <= !throttle || ($urandom_range(99) >= 26);
  end

  // Any byte that neither separates, quotes, comments nor is a single-char token.
  // VT and FF stay in: they are ordinary outside of the whitespace-only rule.
  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    do begin
      b = 8'($urandom);
    end while (b inside {CH_NUL, CH_HASH, CH_SQUOTE, CH_DQUOTE, CH_SPACE, CH_TAB,
                         CH_CR, CH_LF, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE,
                         CH_LBRACK, CH_RBRACK, CH_COMMA, CH_SEMI, CH_COLON});
    return b;
  endfunction

  // One input transaction. Entered and left at a falling edge; valid is left
  // high so back-to-back bytes need no extra assignment.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while (throttle && $urandom_range(99) < 26) begin
      in_ch.valid   <= 1'b0;
      in_ch.in_byte <= 8'($urandom);
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input byte_seq_t seq);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Drain: every expected token byte out, then let the block go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (beats_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Only called after settle(), so the block is idle
  task automatic write_limit(input int v);
    cfg_we    <= 1'b1;
    cfg_wdata <= LIMIT_W'(v);
    @(negedge clk);
    cfg_we    <= 1'b0;
    lim_now = v;
    limit_writes++;
  endtask

  // Mostly short words; now and then one that lands on or just under the limit
  task automatic send_word();
    int   len;
    logic blank;
    blank = ($urandom_range(9) == 0);   // VT/FF only: must be dropped
    if ($urandom_range(99) < 4) begin
      len = lim_now - 1 + $urandom_range(1);
    end else begin
      len = $urandom_range(1, lim_now > 9 ? 8 : lim_now - 1);
    end
    repeat (len) send_byte(blank ? ($urandom_range(1) ? CH_VT : CH_FF) : plain_byte());
  endtask

  // Quoted contents may hold separators and punctuation; sometimes left open
  task automatic send_quoted();
    int len;
    len = $urandom_range(0, lim_now < 6 ? lim_now : 5);
    send_byte(QUOTES[$urandom_range(1)]);
    repeat (len) begin
      if ($urandom_range(3) != 0) begin
        send_byte(plain_byte());
      end else begin
        send_byte($urandom_range(1) ? PUNCT[$urandom_range(8)] : SEPS[$urandom_range(2)]);
      end
    end
    if ($urandom_range(99) < 88) send_byte(QUOTES[$urandom_range(1)]);
  endtask

  // One text line: mostly sane config syntax, some raw noise, always LF-terminated
  task automatic random_line();
    int pick;
    repeat ($urandom_range(1, 6)) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        send_word();
      end else if (pick < 50) begin
        send_byte(PUNCT[$urandom_range(8)]);
      end else if (pick < 65) begin
        send_quoted();
      end else if (pick < 85) begin
        send_byte(SEPS[$urandom_range(2)]);
      end else if (pick < 90) begin
        send_byte($urandom_range(1) ? CH_HASH : CH_NUL);
        repeat ($urandom_range(3)) send_byte(plain_byte());
      end else begin
        send_byte(8'($urandom));
      end
    end
    send_byte(CH_LF);
  endtask

  initial begin
    int target;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, reset limit of 64
    send_text('{"a", "b", CH_SEMI});               // word then punctuation token
    send_text('{CH_SQUOTE, "x", CH_DQUOTE});       // closed by the other quote kind
    send_text('{CH_DQUOTE, CH_DQUOTE});            // empty quoted token: nothing
    send_text('{CH_VT, CH_FF, CH_LF});             // whitespace-only word: nothing
    send_text('{8'hFF, CH_HASH, "z", CH_LF});      // comment flushes 0xFF, eats the rest
    send_text('{CH_SQUOTE, "q", CH_NUL, CH_LF});   // NUL inside quotes loses the token
    send_text('{CH_SQUOTE, "k", CH_LF});           // unclosed quote dropped at newline
    settle();
    write_limit(2);
    send_text('{"a", "b", CH_LF});                 // two bytes hit the limit: dropped
    settle();

    // Random lines, one limit per phase
    for (int p = 0; p < 6; p++) begin
      write_limit(PHASE_LIMIT[p]);
      throttle = (p != 3);
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) random_line();
      settle();
    end

    $display("Sent %0d text bytes over %0d token_limit settings (2 to 64).",
             bytes_sent, limit_writes);
    $display("Checked %0d tokens, %0d token bytes.", tokens_seen, beats_seen);
    if (fail_count == 0 && beats_due == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
